// ===== rtl/core/gspd_pkg.sv =====
// ----------------------------------------------------------------------------
// gspd_pkg
// Shared types and constants of the gain scheduled PD servo with PWM output.
// ----------------------------------------------------------------------------
`default_nettype none

package gspd_pkg;

    // Field widths
    localparam int DIR_W   = 12;   // set point and measured direction
    localparam int ERR_W   = 13;   // control error
    localparam int DUTY_W  = 12;   // duty and duty centre
    localparam int CNT_W   = 12;   // PWM counter and period
    localparam int CFG_W   = 12;   // configuration write data
    localparam int IDX_W   = 2;    // configuration register index
    localparam int S_DATA_W = 16;  // measured_dir padded to whole bytes
    localparam int M_DATA_W = 32;  // pwm_level, duty, error padded

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_SET_POINT   = 2'd0,
        REG_DUTY_CENTER = 2'd1,
        REG_PWM_PERIOD  = 2'd2
    } cfg_reg_t;

    // Item kinds carried in tuser
    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_MEASURE = 1'b1;

    // Register reset values
    localparam logic signed [DIR_W-1:0] SET_POINT_RST   = 12'sd640;
    localparam logic [DUTY_W-1:0]       DUTY_CENTER_RST = 12'd150;
    localparam logic [CNT_W-1:0]        PWM_PERIOD_RST  = 12'd2000;

    // Gain band bounds on |error| (5, 7, 10 and 20 in 1/16 units)
    localparam logic [ERR_W-1:0] BAND_1 = 13'd80;
    localparam logic [ERR_W-1:0] BAND_2 = 13'd112;
    localparam logic [ERR_W-1:0] BAND_3 = 13'd160;
    localparam logic [ERR_W-1:0] BAND_4 = 13'd320;

    // floor(x / 5) = (x * RECIP5) >> RECIP5_SHIFT for x below 2^18
    localparam logic [15:0] RECIP5       = 16'd52429;
    localparam int          RECIP5_SHIFT = 18;

    // Measurement result
    typedef struct packed {
        logic signed [ERR_W-1:0] error;
        logic [DUTY_W-1:0]       duty;
    } pd_result_t;

    // Tick result
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             pin;
    } pwm_result_t;

endpackage : gspd_pkg

`default_nettype wire

// ===== rtl/core/gspd_pd_law.sv =====
// ----------------------------------------------------------------------------
// gspd_pd_law
// Error, gain scheduling and saturated PD duty for one measurement item.
// ----------------------------------------------------------------------------
`default_nettype none

module gspd_pd_law
    import gspd_pkg::*;
(
    input  wire logic signed [DIR_W-1:0] set_point,
    input  wire logic signed [DIR_W-1:0] measured_dir,
    input  wire logic signed [ERR_W-1:0] prev_error,
    input  wire logic [DUTY_W-1:0]       duty_center,
    output pd_result_t                   result
);

    logic signed [ERR_W-1:0] err;
    logic [ERR_W-1:0]        mag;
    logic signed [13:0]      diff;
    logic signed [17:0]      diff_x;
    logic signed [17:0]      diff10;
    logic signed [19:0]      kd_term;
    logic signed [15:0]      err_x;
    logic signed [15:0]      kp_term;
    logic [19:0]             ctr_term;
    logic signed [21:0]      num;
    logic [14:0]             num_div32;
    logic [30:0]             prod;
    logic [12:0]             quot;

    // Error and magnitude
    assign err  = {set_point[DIR_W-1], set_point} - {measured_dir[DIR_W-1], measured_dir};
    assign mag  = err[ERR_W-1] ? (-err) : err;
    assign diff = {err[ERR_W-1], err} - {prev_error[ERR_W-1], prev_error};

    // Derivative: 10 * diff, then scaled by Kd
    assign diff_x = {{4{diff[13]}}, diff};
    assign diff10 = (diff_x <<< 3) + (diff_x <<< 1);

    // Proportional term in tenths, centre term times 160
    assign err_x    = {{3{err[ERR_W-1]}}, err};
    assign ctr_term = ({8'd0, duty_center} << 7) + ({8'd0, duty_center} << 5);

    // Gain bands
    always_comb
    begin
        priority if (mag < BAND_1)
        begin
            kp_term = '0;
            kd_term = {{2{diff10[17]}}, diff10};
        end
        else if (mag < BAND_2)
        begin
            kp_term = err_x;
            kd_term = {{2{diff10[17]}}, diff10} <<< 1;
        end
        else if (mag < BAND_3)
        begin
            kp_term = err_x <<< 1;
            kd_term = {{2{diff10[17]}}, diff10} + ({{2{diff10[17]}}, diff10} <<< 1);
        end
        else if (mag < BAND_4)
        begin
            kp_term = err_x + (err_x <<< 1);
            kd_term = {{2{diff10[17]}}, diff10};
        end
        else
        begin
            kp_term = err_x <<< 2;
            kd_term = {{2{diff10[17]}}, diff10};
        end
    end

    // Exact PD sum, scaled by 160
    assign num = $signed({2'b00, ctr_term}) + {{6{kp_term[15]}}, kp_term}
               + {{2{kd_term[19]}}, kd_term};

    // num / 160 as (num >> 5) / 5 through a reciprocal multiply
    assign num_div32 = num[19:5];
    assign prod      = {16'd0, num_div32} * {15'd0, RECIP5};
    assign quot      = prod[RECIP5_SHIFT+12:RECIP5_SHIFT];

    // Saturation to the duty range
    always_comb
    begin
        result.error = err;
        if (num[21])
            result.duty = '0;
        else if (quot[12])
            result.duty = '1;
        else
            result.duty = quot[DUTY_W-1:0];
    end

endmodule : gspd_pd_law

`default_nettype wire

// ===== rtl/core/gspd_pwm.sv =====
// ----------------------------------------------------------------------------
// gspd_pwm
// PWM counter step with wrap at the period and pin compare against duty.
// ----------------------------------------------------------------------------
`default_nettype none

module gspd_pwm
    import gspd_pkg::*;
(
    input  wire logic [CNT_W-1:0]  tick_count,
    input  wire logic [CNT_W-1:0]  pwm_period,
    input  wire logic [DUTY_W-1:0] duty,
    output pwm_result_t            result
);

    logic [CNT_W:0] count_inc;

    // Wrap to zero once the next count reaches the period
    assign count_inc = {1'b0, tick_count} + {{CNT_W{1'b0}}, 1'b1};

    always_comb
    begin
        if (count_inc >= {1'b0, pwm_period})
            result.count = '0;
        else
            result.count = count_inc[CNT_W-1:0];
        result.pin = (result.count <= duty);
    end

endmodule : gspd_pwm

`default_nettype wire

// ===== rtl/core/gain_scheduled_pd_servo_pwm.sv =====
// ----------------------------------------------------------------------------
// gain_scheduled_pd_servo_pwm
// Gain scheduled PD servo law with a software PWM counter, streaming I/O.
// ----------------------------------------------------------------------------
// Path: an item taken into the input register has its result loaded into the
//   result register as soon as that register is empty or being read.
// Throughput: one item per cycle while m_tready is high; the state update
//   of each item is combinational logic between the input and result registers.
// Reset: rst_n asynchronous, clears counter and errors, duty to 150,
//   registers to their reset values. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module gain_scheduled_pd_servo_pwm
    import gspd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // Input items
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // [11:0] measured_dir, rest zero
    input  wire logic                s_tuser,   // [0] func
    // Result items
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // [0] pwm_level, [12:1] duty,
                                                // [25:13] error, rest zero
    // Configuration writes
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data
);

    // Configuration registers
    logic signed [DIR_W-1:0] set_point_reg;
    logic [DUTY_W-1:0]       duty_center_reg;
    logic [CNT_W-1:0]        pwm_period_reg;

    // Controller state
    logic [CNT_W-1:0]        tick_count_reg,  tick_count_next;
    logic signed [ERR_W-1:0] cur_err_reg,     cur_err_next;
    logic signed [ERR_W-1:0] prev_err_reg,    prev_err_next;
    logic [DUTY_W-1:0]       duty_reg,        duty_next;
    logic                    pin_reg,         pin_next;

    // Input and result registers
    logic                    in_valid_reg;
    logic                    in_func_reg;
    logic signed [DIR_W-1:0] in_dir_reg;
    logic                    out_valid_reg;
    logic [M_DATA_W-1:0]     out_data_reg,    out_data_next;

    logic                    advance;
    logic                    in_take;
    pd_result_t              pd_res;
    pwm_result_t             pwm_res;

    // Handshake
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_take   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_point_reg   <= SET_POINT_RST;
            duty_center_reg <= DUTY_CENTER_RST;
            pwm_period_reg  <= PWM_PERIOD_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SET_POINT:   set_point_reg   <= cfg_data;
                REG_DUTY_CENTER: duty_center_reg <= cfg_data;
                REG_PWM_PERIOD:  pwm_period_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_func_reg <= s_tuser;
            in_dir_reg  <= s_tdata[DIR_W-1:0];
        end
    end

    // Measurement path
    gspd_pd_law u_pd_law (
        .set_point    (set_point_reg),
        .measured_dir (in_dir_reg),
        .prev_error   (cur_err_reg),
        .duty_center  (duty_center_reg),
        .result       (pd_res)
    );

    // Tick path
    gspd_pwm u_pwm (
        .tick_count (tick_count_reg),
        .pwm_period (pwm_period_reg),
        .duty       (duty_reg),
        .result     (pwm_res)
    );

    // State update for the item in the input register
    always_comb
    begin
        tick_count_next = tick_count_reg;
        cur_err_next    = cur_err_reg;
        prev_err_next   = prev_err_reg;
        duty_next       = duty_reg;
        pin_next        = pin_reg;
        if (in_func_reg == FUNC_MEASURE)
        begin
            prev_err_next = cur_err_reg;
            cur_err_next  = pd_res.error;
            duty_next     = pd_res.duty;
        end
        else
        begin
            tick_count_next = pwm_res.count;
            pin_next        = pwm_res.pin;
        end
        out_data_next = {{(M_DATA_W-1-DUTY_W-ERR_W){1'b0}},
                         cur_err_next, duty_next, pin_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            cur_err_reg    <= '0;
            prev_err_reg   <= '0;
            duty_reg       <= DUTY_CENTER_RST;
            pin_reg        <= 1'b0;
        end
        else if (advance)
        begin
            tick_count_reg <= tick_count_next;
            cur_err_reg    <= cur_err_next;
            prev_err_reg   <= prev_err_next;
            duty_reg       <= duty_next;
            pin_reg        <= pin_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= out_data_next;
    end

    // Checks
    a_cnt_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_func_reg == FUNC_TICK) |=>
            (tick_count_reg == '0) || (tick_count_reg < $past(pwm_period_reg)))
        else $error("PWM counter not below period after a tick");

    a_meas_keeps_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_func_reg == FUNC_MEASURE) |=> $stable(tick_count_reg))
        else $error("measurement item moved the PWM counter");

    a_tick_keeps_err: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_func_reg == FUNC_TICK) |=>
            $stable(cur_err_reg) && $stable(prev_err_reg) && $stable(duty_reg))
        else $error("tick item changed the error or duty state");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid && (m_tdata[0] == pin_reg)
            && (m_tdata[DUTY_W:1] == duty_reg))
        else $error("result item does not match controller state");

endmodule : gain_scheduled_pd_servo_pwm

`default_nettype wire
